>>> src/phase_unwrap_scaled_exponential_top_defines.svh
// Assertion macros for the phase unwrap and scaled exponential block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef PHASE_UNWRAP_SCALED_EXPONENTIAL_TOP_DEFINES_SVH
`define PHASE_UNWRAP_SCALED_EXPONENTIAL_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PUSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pusc check failed");

// Next-cycle implication, checked outside reset.
`define PUSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pusc check failed");

`endif

>>> src/pusc_pkg.sv
// Package of the phase unwrap and scaled exponential block.
// Holds widths, CORDIC constants and the rounding helper; no dependencies.
`default_nettype none
package pusc_pkg;

  localparam int SAMPLE_WIDTH      = 16;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int SCALE_WIDTH       = 24;
  localparam int PHASE_WIDTH       = 17;
  localparam int TURN_WIDTH        = 16;
  localparam int TOL_WIDTH         = 17;
  localparam int CW                = 34;  // CORDIC x and y datapath
  localparam int ZW                = 24;  // CORDIC angle datapath
  localparam int SHW               = 5;   // shift amount of one cell
  localparam int PROD_WIDTH        = 32;
  localparam logic [CW-1:0] COS_GAIN_Q30 = CW'(652032874);
  localparam logic signed [ZW-1:0] PI_Z  = ZW'(32768 * 16);

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_TOLERANCE   = 2'd0,
    REG_INPUT_REAL  = 2'd1,
    REG_COMMON_SCL  = 2'd2,
    REG_SCALE_ITEM  = 2'd3
  } cfg_reg_e;

  // atan(2^-i) with 2^20 units per turn.
  function automatic logic [ZW-1:0] atan_tab(input int unsigned i);
    logic [ZW-1:0] r;
    case (i)
      0:  r = ZW'(131072);
      1:  r = ZW'(77376);
      2:  r = ZW'(40884);
      3:  r = ZW'(20753);
      4:  r = ZW'(10417);
      5:  r = ZW'(5213);
      6:  r = ZW'(2607);
      7:  r = ZW'(1304);
      8:  r = ZW'(652);
      9:  r = ZW'(326);
      10: r = ZW'(163);
      11: r = ZW'(81);
      12: r = ZW'(41);
      13: r = ZW'(20);
      14: r = ZW'(10);
      15: r = ZW'(5);
      16: r = ZW'(3);
      17: r = ZW'(1);
      18: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q30 to Q15 with half-up rounding and saturation.
  function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
    logic signed [CW:0] t;
    logic signed [CW:0] r;
    logic signed [15:0] o;
    t = {v[CW-1], v} + (CW+1)'(16384);
    r = t >>> 15;
    if (r > (CW+1)'(32767)) begin
      o = 16'sh7fff;
    end else if (r < -(CW+1)'(32768)) begin
      o = 16'sh8000;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

  // Beat state carried beside the angle CORDIC.
  typedef struct packed {
    logic                   inv;
    logic                   ls;
    logic                   zero;
    logic                   neg;
    logic [SCALE_WIDTH-1:0] scale;
  } vec_side_t;

  // Beat state carried beside the sine and cosine CORDIC.
  typedef struct packed {
    logic       inv;
    logic [1:0] quad;
  } rot_side_t;

endpackage
`default_nettype wire

>>> src/pusc_cordic_cell.sv
// One CORDIC micro-rotation stage, in vectoring or rotating mode.
// Depends on pusc_pkg for the datapath widths.
`default_nettype none
module pusc_cordic_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        rotate_i,
  input  logic [pusc_pkg::SHW-1:0]    shift_i,
  input  logic [pusc_pkg::ZW-1:0]     atan_i,
  input  logic                        valid_i,
  input  logic signed [pusc_pkg::CW-1:0] x_i,
  input  logic signed [pusc_pkg::CW-1:0] y_i,
  input  logic signed [pusc_pkg::ZW-1:0] z_i,
  output logic                        valid_o,
  output logic signed [pusc_pkg::CW-1:0] x_o,
  output logic signed [pusc_pkg::CW-1:0] y_o,
  output logic signed [pusc_pkg::ZW-1:0] z_o
);
  import pusc_pkg::*;

  logic                 valid_q;
  logic signed [CW-1:0] x_q, x_d, y_q, y_d, dx, dy;
  logic signed [ZW-1:0] z_q, z_d;
  logic                 sub;

  // Direction follows the angle sign when rotating, the y sign when vectoring.
  always_comb begin
    dx  = y_i >>> shift_i;
    dy  = x_i >>> shift_i;
    sub = rotate_i ? ~z_i[ZW-1] : y_i[CW-1];
    if (sub) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - $signed(atan_i);
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + $signed(atan_i);
    end
  end

  // Valid flag is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule
`default_nettype wire

>>> src/pusc_unwrap.sv
// Unwrap recurrence along a line and the multiplication by the scale.
// Depends on pusc_pkg; two register stages: unwrapped phase, then product.
`default_nettype none
module pusc_unwrap (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [pusc_pkg::TOL_WIDTH-1:0]    tolerance_i,
  input  logic                              valid_i,
  input  logic                              inv_i,
  input  logic                              ls_i,
  input  logic signed [pusc_pkg::PHASE_WIDTH-1:0] phase_i,
  input  logic [pusc_pkg::SCALE_WIDTH-1:0]  scale_i,
  output logic                              valid_o,
  output logic                              inv_o,
  output logic [pusc_pkg::PROD_WIDTH-1:0]   prod_o
);
  import pusc_pkg::*;

  logic signed [PHASE_WIDTH-1:0] last_q, last_d;
  logic                          last_inv_q, last_inv_d;
  logic [TURN_WIDTH-1:0]         turn_q, turn_d;
  logic signed [18:0]            dp, w, diff;
  logic [16:0]                   mag;
  logic [PROD_WIDTH-1:0]         u_d, u_q, prod_q;
  logic [SCALE_WIDTH-1:0]        scale_q;
  logic                          v1_q, inv1_q, v2_q, inv2_q;

  // Step to the previous phase and the turn count it implies.
  always_comb begin
    dp   = 19'(phase_i) - 19'(last_q);
    w    = 19'($signed(dp[15:0]));
    if (w == -19'sd32768 && dp > 19'sd0) begin
      w = 19'sd32768;
    end
    diff = w - dp;
    mag  = dp[18] ? 17'(-dp) : 17'(dp);
    last_d     = last_q;
    last_inv_d = last_inv_q;
    turn_d     = turn_q;
    if (valid_i) begin
      if (inv_i) begin
        last_d     = '0;
        last_inv_d = 1'b1;
        turn_d     = '0;
      end else begin
        last_d     = phase_i;
        last_inv_d = 1'b0;
        if (ls_i || last_inv_q) begin
          turn_d = '0;
        end else if (mag >= tolerance_i) begin
          if (diff == 19'sd65536) begin
            turn_d = turn_q + TURN_WIDTH'(1);
          end else if (diff == -19'sd65536) begin
            turn_d = turn_q - TURN_WIDTH'(1);
          end
        end
      end
    end
    u_d = PROD_WIDTH'(phase_i) + {turn_d, 16'b0};
  end

  // Line state, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= '0;
      last_inv_q <= 1'b1;
      turn_q     <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
    end else if (en_i) begin
      last_q     <= last_d;
      last_inv_q <= last_inv_d;
      turn_q     <= turn_d;
      v1_q       <= valid_i;
      v2_q       <= v1_q;
    end
  end

  // Unwrapped phase, then its product with the scale modulo 2^32.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q     <= u_d;
      scale_q <= scale_i;
      inv1_q  <= inv_i;
      prod_q  <= PROD_WIDTH'(u_q * PROD_WIDTH'($signed(scale_q)));
      inv2_q  <= inv1_q;
    end
  end

  assign valid_o = v2_q;
  assign inv_o   = inv2_q;
  assign prod_o  = prod_q;

endmodule
`default_nettype wire

>>> src/phase_unwrap_scaled_exponential_top.sv
// Usage: one sample beat per clock cycle is taken and one result beat per
// cycle is given. The rate is set by a fully pipelined datapath: a chain
// of 16 angle CORDIC cells, the unwrap recurrence, a 32-bit multiply
// stage and a chain of 16 sine and cosine CORDIC cells. The whole pipeline
// holds while the output beat waits. Configuration is taken from the write
// port at any edge with cfg_we_i high and should only change while the
// block is empty.
// Top level; depends on pusc_pkg, pusc_cordic_cell, pusc_unwrap and the
// assertion macro header.
`default_nettype none
`include "phase_unwrap_scaled_exponential_top_defines.svh"
module phase_unwrap_scaled_exponential_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [55:0] s_tdata_i,   // sample_re, sample_im, item_scale
  input  logic [1:0]  s_tuser_i,   // sample_invalid, line_start
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,   // cos_out, sin_out
  output logic        m_tuser_o,   // out_invalid
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);
  import pusc_pkg::*;

  localparam int N = CORDIC_ITERATIONS;

  // Configuration registers.
  logic [TOL_WIDTH-1:0]   tol_q;
  logic                   real_q, scale_item_q;
  logic [SCALE_WIDTH-1:0] common_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q          <= TOL_WIDTH'(32768);
      real_q         <= 1'b0;
      common_scale_q <= SCALE_WIDTH'(65536);
      scale_item_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_TOLERANCE:  tol_q          <= cfg_data_i[TOL_WIDTH-1:0];
        REG_INPUT_REAL: real_q         <= cfg_data_i[0];
        REG_COMMON_SCL: common_scale_q <= cfg_data_i[SCALE_WIDTH-1:0];
        REG_SCALE_ITEM: scale_item_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline advances whenever the output register is free or being taken.
  logic en, out_valid_q;
  assign en         = !out_valid_q || m_tready_i;
  assign s_tready_o = en;

  // Input unpacking and angle CORDIC start values.
  logic signed [SAMPLE_WIDTH-1:0] re, im;
  logic signed [CW-1:0]           x0, y0;
  logic signed [ZW-1:0]           z0;
  vec_side_t                      side_in;

  always_comb begin
    re = s_tdata_i[15:0];
    im = real_q ? '0 : s_tdata_i[31:16];
    x0 = CW'(re) <<< 8;
    y0 = CW'(im) <<< 8;
    z0 = '0;
    if (re < 0) begin
      x0 = -x0;
      y0 = -y0;
      z0 = (im >= 0) ? PI_Z : -PI_Z;
    end
    side_in.inv   = s_tuser_i[0];
    side_in.ls    = s_tuser_i[1];
    side_in.zero  = (im == '0);
    side_in.neg   = re[SAMPLE_WIDTH-1];
    side_in.scale = scale_item_q ? s_tdata_i[55:32] : common_scale_q;
  end

  // Angle CORDIC chain; index 0 is the input register.
  logic                 vv [0:N];
  logic signed [CW-1:0] vx [0:N];
  logic signed [CW-1:0] vy [0:N];
  logic signed [ZW-1:0] vz [0:N];
  vec_side_t            vs_q [0:N];
  logic                 v0_q;
  logic signed [CW-1:0] x0_q, y0_q;
  logic signed [ZW-1:0] z0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q     <= x0;
      y0_q     <= y0;
      z0_q     <= z0;
      vs_q[0]  <= side_in;
      for (int k = 1; k <= N; k++) begin
        vs_q[k] <= vs_q[k-1];
      end
    end
  end

  assign vv[0] = v0_q;
  assign vx[0] = x0_q;
  assign vy[0] = y0_q;
  assign vz[0] = z0_q;

  for (genvar g = 0; g < N; g++) begin : g_vec
    pusc_cordic_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .rotate_i (1'b0),
      .shift_i  (SHW'(g)),
      .atan_i   (atan_tab(g)),
      .valid_i  (vv[g]),
      .x_i      (vx[g]),
      .y_i      (vy[g]),
      .z_i      (vz[g]),
      .valid_o  (vv[g+1]),
      .x_o      (vx[g+1]),
      .y_o      (vy[g+1]),
      .z_o      (vz[g+1])
    );
  end

  // Angle in phase units, rounded and wrapped into (-pi, pi].
  logic signed [ZW-1:0]          zr;
  logic signed [19:0]            r;
  logic signed [PHASE_WIDTH-1:0] p_d, p_q;
  logic                          vp_q;
  vec_side_t                     sp_q;

  always_comb begin
    zr = vz[N] + ZW'(8);
    r  = 20'(zr >>> 4);
    if (r <= -20'sd32768) begin
      r = r + 20'sd65536;
    end
    if (r > 20'sd32768) begin
      r = r - 20'sd65536;
    end
    p_d = PHASE_WIDTH'(r);
    if (vs_q[N].zero) begin
      p_d = vs_q[N].neg ? PHASE_WIDTH'(32768) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= vv[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q  <= p_d;
      sp_q <= vs_q[N];
    end
  end

  // Unwrap and scale.
  logic                  vm, invm;
  logic [PROD_WIDTH-1:0] prod;

  pusc_unwrap u_unwrap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .tolerance_i (tol_q),
    .valid_i     (vp_q),
    .inv_i       (sp_q.inv),
    .ls_i        (sp_q.ls),
    .phase_i     (p_q),
    .scale_i     (sp_q.scale),
    .valid_o     (vm),
    .inv_o       (invm),
    .prod_o      (prod)
  );

  // Quadrant split and rotation CORDIC start values.
  logic [PROD_WIDTH-1:0] pr;
  logic [15:0]           ang, aq, dd;
  logic [1:0]            quad;
  logic                  ra_v_q;
  logic signed [ZW-1:0]  ra_z_q;
  rot_side_t             rs_q [0:N];

  always_comb begin
    pr   = prod + PROD_WIDTH'(32768);
    ang  = pr[31:16];
    aq   = ang + 16'd8192;
    quad = aq[15:14];
    dd   = ang - {quad, 14'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ra_v_q <= 1'b0;
    end else if (en) begin
      ra_v_q <= vm;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ra_z_q       <= ZW'($signed(dd)) <<< 4;
      rs_q[0].inv  <= invm;
      rs_q[0].quad <= quad;
      for (int k = 1; k <= N; k++) begin
        rs_q[k] <= rs_q[k-1];
      end
    end
  end

  // Sine and cosine CORDIC chain.
  logic                 rv [0:N];
  logic signed [CW-1:0] rx [0:N];
  logic signed [CW-1:0] ry [0:N];
  logic signed [ZW-1:0] rz [0:N];

  assign rv[0] = ra_v_q;
  assign rx[0] = $signed(COS_GAIN_Q30);
  assign ry[0] = '0;
  assign rz[0] = ra_z_q;

  for (genvar g = 0; g < N; g++) begin : g_rot
    pusc_cordic_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .rotate_i (1'b1),
      .shift_i  (SHW'(g)),
      .atan_i   (atan_tab(g)),
      .valid_i  (rv[g]),
      .x_i      (rx[g]),
      .y_i      (ry[g]),
      .z_i      (rz[g]),
      .valid_o  (rv[g+1]),
      .x_o      (rx[g+1]),
      .y_o      (ry[g+1]),
      .z_o      (rz[g+1])
    );
  end

  // Quadrant fold-back, rounding to Q15 and the output register.
  logic signed [CW-1:0] cf, sf;
  logic signed [15:0]   cos_d, sin_d, cos_q, sin_q;
  logic                 inv_q;

  always_comb begin
    case (rs_q[N].quad)
      2'd0: begin cf = rx[N];  sf = ry[N];  end
      2'd1: begin cf = -ry[N]; sf = rx[N];  end
      2'd2: begin cf = -rx[N]; sf = -ry[N]; end
      default: begin cf = ry[N]; sf = -rx[N]; end
    endcase
    cos_d = rs_q[N].inv ? '0 : to_q15(cf);
    sin_d = rs_q[N].inv ? '0 : to_q15(sf);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= rv[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cos_q <= cos_d;
      sin_q <= sin_d;
      inv_q <= rs_q[N].inv;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {sin_q, cos_q};
  assign m_tuser_o  = inv_q;

  // Checks on the pipeline control and the invalid-beat result.
  `PUSC_ASSERT_IMP(a_inv_zero, m_tvalid_o && m_tuser_o, m_tdata_o == 32'd0)
  `PUSC_ASSERT_IMP(a_stall_holds, m_tvalid_o && !m_tready_i, !s_tready_o)
  `PUSC_ASSERT_NXT(a_last_moves, rv[N] && s_tready_o, m_tvalid_o)

endmodule
`default_nettype wire

>>> tb/tb_phase_unwrap_scaled_exponential_top.sv
// Testbench of the phase unwrap and scaled exponential block.
// Needs pusc_pkg and the top level; predicts every result beat and compares it.
`default_nettype none
module tb_phase_unwrap_scaled_exponential_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pusc_pkg::*;

  localparam int LATENCY = 38;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
    logic               inv;
  } trig_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [55:0] s_tdata_i = '0;
  logic [1:0]  s_tuser_i = '0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [31:0] m_tdata_o;
  logic        m_tuser_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;

  // Predictor state and its copy of the registers.
  logic [16:0]        tol_q;
  logic               real_q;
  logic signed [23:0] common_scl_q;
  logic               scl_item_q;
  logic signed [16:0] prev_phase_q;
  logic               prev_inv_q;
  logic [15:0]        turns_q;

  trig_t   trig_queue[$];
  int      n_errors = 0;
  longint  n_cycles = 0;
  bit      quiet_in = 0;
  bit      quiet_out = 0;

  phase_unwrap_scaled_exponential_top i_dut (.*);

  always #1 clk_i = ~clk_i;

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [ZW-1:0] arctan_step(int i);
    case (i)
      0: return 131072;  1: return 77376;  2: return 40884;  3: return 20753;
      4: return 10417;   5: return 5213;   6: return 2607;   7: return 1304;
      8: return 652;     9: return 326;   10: return 163;   11: return 81;
      12: return 41;    13: return 20;    14: return 10;    15: return 5;
      default: return 0;
    endcase
  endfunction

  // Vectoring CORDIC: angle of (re, im) in 65536 units per turn.
  function automatic longint sample_angle(longint re, longint im);
    longint x, y, z, dx, dy, r;
    if (im == 0) return (re >= 0) ? 0 : 32768;
    x = re * 256;
    y = im * 256;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = (im >= 0) ? 32768 * 16 : -32768 * 16;
    end
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_step(i);
      end else begin
        x -= dx; y += dy; z -= arctan_step(i);
      end
    end
    r = shr(z + 8, 4);
    if (r <= -32768) r += 65536;
    if (r > 32768) r -= 65536;
    return r;
  endfunction

  function automatic logic signed [15:0] round_q15(longint v);
    longint r;
    r = shr(v + 16384, 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Rotating CORDIC with quadrant folding.
  function automatic void cos_sin_of(logic [15:0] a, output logic signed [15:0] c,
                                     output logic signed [15:0] s);
    logic [1:0] q;
    longint d, x, y, z, dx, dy, cc, ss;
    q = 2'((int'(a) + 8192) >> 14);
    d = longint'($signed(16'(int'(a) - int'(q) * 16384)));
    x = 652032874;
    y = 0;
    z = d * 16;
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    case (q)
      2'd0: begin cc = x;  ss = y;  end
      2'd1: begin cc = -y; ss = x;  end
      2'd2: begin cc = -x; ss = -y; end
      default: begin cc = y; ss = -x; end
    endcase
    c = round_q15(cc);
    s = round_q15(ss);
  endfunction

  // Unwrap, scale and look up one sample; queues the expected beat.
  task automatic predict_beat(logic signed [15:0] re, logic signed [15:0] im, logic inv,
                              logic ls, logic signed [23:0] scl);
    trig_t t;
    longint p, dp, w, mag, u, prod, scale;
    logic [15:0] a;
    if (inv) begin
      t = '{cos_v: 0, sin_v: 0, inv: 1'b1};
      prev_inv_q = 1'b1;
      turns_q = '0;
      prev_phase_q = '0;
    end else begin
      p = real_q ? ((re >= 0) ? 0 : 32768) : sample_angle(re, im);
      if (ls || prev_inv_q) begin
        turns_q = '0;
      end else begin
        dp = p - longint'(prev_phase_q);
        w = longint'($signed(16'(dp)));
        mag = (dp < 0) ? -dp : dp;
        if (w == -32768 && dp > 0) w = 32768;
        if (mag >= longint'(tol_q)) begin
          if (w - dp == 65536) turns_q = turns_q + 16'd1;
          else if (w - dp == -65536) turns_q = turns_q - 16'd1;
        end
      end
      prev_phase_q = p[16:0];
      prev_inv_q = 1'b0;
      scale = scl_item_q ? longint'(scl) : longint'(common_scl_q);
      u = p + (longint'(turns_q) << 16);
      prod = u * scale;
      a = 16'((prod + 32768) >>> 16);
      t.inv = 1'b0;
      cos_sin_of(a, t.cos_v, t.sin_v);
    end
    trig_queue = {trig_queue, t};
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    n_errors++;
  endtask

  // Sends one sample beat, idling at random beforehand.
  task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im, logic inv,
                             logic ls, logic signed [23:0] scl);
    while (!quiet_in && $urandom_range(99) < 29) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i <= {scl, im, re};
    s_tuser_i <= {ls, inv};
    predict_beat(re, im, inv, ls, scl);
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  task automatic drain;
    s_tvalid_i <= 1'b0;
    while (trig_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_TOLERANCE:  tol_q = {val[16:0]};
      REG_INPUT_REAL: real_q = val[0];
      REG_COMMON_SCL: common_scl_q = val;
      default:        scl_item_q = val[0];
    endcase
  endtask

  task automatic configure(logic [16:0] tol, logic rl, logic signed [23:0] cs, logic si);
    drain();
    write_reg(REG_TOLERANCE, 24'(tol));
    write_reg(REG_INPUT_REAL, 24'(rl));
    write_reg(REG_COMMON_SCL, cs);
    write_reg(REG_SCALE_ITEM, 24'(si));
    cfg_we_i <= 1'b0;
  endtask

  // Random sample; mostly valid lines with occasional restarts and NaNs.
  task automatic send_random(int n, bit smooth);
    logic signed [15:0] re, im;
    int ang;
    for (int k = 0; k < n; k++) begin
      if (smooth) begin
        ang = $urandom_range(7) * 45 + $urandom_range(20);
        re = 16'($rtoi(30000.0 * $cos(ang * 3.14159265 / 180.0)));
        im = 16'($rtoi(30000.0 * $sin(ang * 3.14159265 / 180.0)));
      end else begin
        re = 16'($urandom);
        im = ($urandom_range(9) == 0) ? 16'sd0 : 16'($urandom);
      end
      send_sample(re, im, $urandom_range(19) == 0, $urandom_range(15) == 0, 24'($urandom));
    end
  endtask

  task automatic test_extremes;
    configure(17'd32768, 1'b0, 24'sd65536, 1'b0);
    send_sample(16'sh7fff, 16'sd0, 0, 1, 0);
    send_sample(-16'sd32768, 16'sd0, 0, 0, 0);
    send_sample(-16'sd32768, 16'sh7fff, 0, 0, 0);
    send_sample(-16'sd32768, -16'sd32768, 0, 0, 0);
    send_sample(16'sd0, 16'sd0, 0, 0, 0);
    send_sample(16'sd1, -16'sd1, 0, 0, 0);
    send_sample(16'sd5, 16'sd5, 1, 0, 0);
    send_sample(-16'sd100, 16'sd3, 0, 0, 0);
    send_sample(-16'sd100, -16'sd3, 0, 0, 0);
    send_sample(16'sd0, 16'sh7fff, 0, 1, 0);
    send_sample(16'sd0, -16'sd32768, 0, 0, 0);
  endtask

  task automatic test_real_mode;
    configure(17'd0, 1'b1, 24'sh7fffff, 1'b0);
    send_sample(-16'sd1, 16'sd9, 0, 1, 0);
    send_sample(16'sd0, 16'sd9, 0, 0, 0);
    send_sample(-16'sd32768, -16'sd1, 0, 0, 0);
    send_sample(16'sh7fff, 16'sd1, 0, 0, 0);
  endtask

  task automatic test_item_scale;
    configure(17'd65536, 1'b0, -24'sd8388608, 1'b1);
    send_sample(16'sd100, 16'sd100, 0, 1, 24'sh7fffff);
    send_sample(-16'sd100, 16'sd1, 0, 0, 24'sh800000);
    send_sample(-16'sd100, -16'sd1, 0, 0, 24'sd0);
    send_sample(16'sd7, -16'sd3, 0, 0, 24'shffffff);
  endtask

  task automatic test_random;
    configure(17'd32768, 1'b0, 24'sd196608, 1'b0);
    send_random(400, 1);
    configure(17'($urandom_range(65536)), 1'b0, 24'($urandom), 1'b1);
    quiet_in = 1;
    quiet_out = 1;
    send_random(300, 0);
    quiet_in = 0;
    quiet_out = 0;
    configure(17'd16384, 1'b0, -24'sd131072, 1'b0);
    send_random(400, 1);
    configure(17'd1, 1'b1, 24'($urandom), 1'b1);
    send_random(300, 0);
    configure(17'd65535, 1'b0, 24'sd65536, 1'b1);
    send_random(380, 0);
  endtask

  // Result checker and receiver stalls.
  always @(posedge clk_i) begin
    trig_t want;
    if (m_tvalid_o && m_tready_i) begin
      if (trig_queue.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = trig_queue.pop_front();
        if (m_tdata_o[15:0] !== want.cos_v)
          report_mismatch("cos_out", $signed(m_tdata_o[15:0]), want.cos_v);
        if (m_tdata_o[31:16] !== want.sin_v)
          report_mismatch("sin_out", $signed(m_tdata_o[31:16]), want.sin_v);
        if (m_tuser_o !== want.inv)
          report_mismatch("out_invalid", m_tuser_o, want.inv);
      end
    end
    m_tready_i <= rst_ni && (quiet_out || $urandom_range(99) >= 29);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    tol_q = 17'd32768;
    real_q = 1'b0;
    common_scl_q = 24'sd65536;
    scl_item_q = 1'b0;
    prev_phase_q = '0;
    prev_inv_q = 1'b1;
    turns_q = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_real_mode();
    test_item_scale();
    test_random();
    drain();
    if (n_errors == 0 && trig_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
